[design/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W        = 16;
  localparam int MAG_W         = 17;  // magnitude of a sum or difference of two elements

  // Path select codes
  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  // Data that rides along with an item through the cell chains
  typedef struct packed {
    logic [1:0]                  sel;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } rmq_pay_t;

endpackage

[design/rmq_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring square root; resolves one root bit per cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int VW = 34,
  parameter int RW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [VW-1:0] in_v,
  input  logic [RW-1:0] in_rem,
  input  logic [RW-1:0] in_root,
  input  rmq_pay_t      in_pay,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_v,
  output logic [RW-1:0] out_rem,
  output logic [RW-1:0] out_root,
  output rmq_pay_t      out_pay
);

  logic          en;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          take;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {in_rem, in_v[VW-1 -: 2]};
    trial  = {in_root, 2'b01};
    take   = (rem_sh >= trial);
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_v    <= {in_v[VW-3:0], 2'b00};
      out_rem  <= take ? diff[RW-1:0] : rem_sh[RW-1:0];
      out_root <= {in_root[RW-2:0], take};
      out_pay  <= in_pay;
    end
  end

endmodule

[design/rmq_div_cell.sv]
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a restoring divide for all three lanes at once.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
  parameter int NW = 32,
  parameter int RW = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0][NW-1:0]  in_num,
  input  logic [2:0][RW:0]    in_rem,
  input  logic [2:0][NW-1:0]  in_q,
  input  logic [RW:0]         in_den,
  input  logic [RW-1:0]       in_half,
  input  rmq_pay_t            in_pay,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0][NW-1:0]  out_num,
  output logic [2:0][RW:0]    out_rem,
  output logic [2:0][NW-1:0]  out_q,
  output logic [RW:0]         out_den,
  output logic [RW-1:0]       out_half,
  output rmq_pay_t            out_pay
);

  logic              en;
  logic [2:0][RW+1:0] rem_sh;
  logic [2:0][RW+1:0] diff;
  logic [2:0]         take;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // shift in next numerator bit, subtract divisor if it fits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_sh[k] = {in_rem[k], in_num[k][NW-1]};
      take[k]   = (rem_sh[k] >= {1'b0, in_den});
      diff[k]   = rem_sh[k] - {1'b0, in_den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        out_num[k] <= {in_num[k][NW-2:0], 1'b0};
        out_rem[k] <= take[k] ? diff[k][RW:0] : rem_sh[k][RW:0];
        out_q[k]   <= {in_q[k][NW-2:0], take[k]};
      end
      out_den  <= in_den;
      out_half <= in_half;
      out_pay  <= in_pay;
    end
  end

endmodule

[design/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix (signed fixed point) to a unit quaternion.
// ----------------------------------------------------------------------------
//  channel  dir  fields (low bit first)                      transfer when
//  s_*      in   elem_00,01,02,10,11,12,20,21,22 (16b each)  s_tvalid & s_tready
//  m_*      out  quat_x, quat_y, quat_z, quat_w (16b each)   m_tvalid & m_tready
//
//  One matrix per cycle sustained unless m_tready stalls. The path is one prep
//  stage, RW square root cells (one root bit each), one scale stage, NW divide
//  cells (one quotient bit each) and the output register.
//  Every cell moves when its successor is empty or moving, so bubbles collapse
//  and input keeps flowing while a result waits. rst clears all valid flags.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // elem_00..elem_22, 16 bits each, row major
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata   // quat_x, quat_y, quat_z, quat_w, 16 bits each
);

  localparam int F    = FRAC_BITS;
  localparam int RADW = ((F > 17) ? F : 17) + 2;
  localparam int VW   = RADW + F;
  localparam int VW2  = VW + (VW % 2);
  localparam int RW   = VW2 / 2;
  localparam int NW   = F + 18;
  localparam int CW   = ((F + 2) > 18) ? (F + 2) : 18;
  localparam logic [RADW-1:0] ONE = RADW'(1) << F;

  // ---------------- prep: trace, path, radicand, cross terms ----------------
  logic signed [ELEM_W-1:0] m [9];
  logic signed [RADW:0]     tr, rad_s, one_s;
  logic [1:0]               sel_c;
  logic signed [17:0]       t [3];
  rmq_pay_t                 pay_c;

  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = s_tdata[i*ELEM_W +: ELEM_W];
    one_s = $signed({1'b0, ONE});
    tr    = (RADW+1)'(m[0]) + (RADW+1)'(m[4]) + (RADW+1)'(m[8]);
    if (!tr[RADW]) begin
      sel_c = SEL_TRACE;
      rad_s = one_s + tr;
      t[0]  = 18'(m[5]) - 18'(m[7]);
      t[1]  = 18'(m[6]) - 18'(m[2]);
      t[2]  = 18'(m[1]) - 18'(m[3]);
    end else if (m[0] >= m[4] && m[0] >= m[8]) begin
      sel_c = SEL_X;
      rad_s = one_s - (RADW+1)'(m[4]) - (RADW+1)'(m[8]) + (RADW+1)'(m[0]);
      t[0]  = 18'(m[1]) + 18'(m[3]);
      t[1]  = 18'(m[2]) + 18'(m[6]);
      t[2]  = 18'(m[5]) - 18'(m[7]);
    end else if (m[4] >= m[8]) begin
      sel_c = SEL_Y;
      rad_s = one_s - (RADW+1)'(m[0]) - (RADW+1)'(m[8]) + (RADW+1)'(m[4]);
      t[0]  = 18'(m[1]) + 18'(m[3]);
      t[1]  = 18'(m[5]) + 18'(m[7]);
      t[2]  = 18'(m[6]) - 18'(m[2]);
    end else begin
      sel_c = SEL_Z;
      rad_s = one_s - (RADW+1)'(m[0]) - (RADW+1)'(m[4]) + (RADW+1)'(m[8]);
      t[0]  = 18'(m[2]) + 18'(m[6]);
      t[1]  = 18'(m[5]) + 18'(m[7]);
      t[2]  = 18'(m[1]) - 18'(m[3]);
    end
    if (rad_s <= 0) rad_s = (RADW+1)'(1);
    pay_c.sel = sel_c;
    for (int k = 0; k < 3; k++) begin
      pay_c.neg[k] = t[k][17];
      pay_c.mag[k] = t[k][17] ? 17'(-t[k]) : t[k][16:0];
    end
  end

  logic            prep_valid, prep_ready, prep_en;
  logic [RADW-1:0] prep_rad;
  rmq_pay_t        prep_pay;

  assign prep_en  = !prep_valid || prep_ready;
  assign s_tready = prep_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (prep_en) begin
      prep_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_en && s_tvalid) begin
      prep_rad <= rad_s[RADW-1:0];
      prep_pay <= pay_c;
    end
  end

  // ---------------- square root chain ----------------
  logic              sq_valid [RW+1];
  logic              sq_ready [RW+1];
  logic [VW2-1:0]    sq_v     [RW+1];
  logic [RW-1:0]     sq_rem   [RW+1];
  logic [RW-1:0]     sq_root  [RW+1];
  rmq_pay_t          sq_pay   [RW+1];

  assign sq_valid[0] = prep_valid;
  assign prep_ready  = sq_ready[0];
  assign sq_v[0]     = VW2'({prep_rad, {F{1'b0}}});
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pay[0]   = prep_pay;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.VW(VW2), .RW(RW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_v      (sq_v[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_pay    (sq_pay[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_v     (sq_v[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_pay   (sq_pay[i+1])
    );
  end

  // ---------------- scale stage: divisor 2r, half, numerators ----------------
  logic              sc_valid, sc_ready, sc_en;
  logic [RW-1:0]     root_f;
  logic [RW:0]       half_sum;
  logic [2:0][NW-1:0] sc_num;
  logic [RW:0]       sc_den;
  logic [RW-1:0]     sc_half;
  rmq_pay_t          sc_pay;

  assign root_f       = (sq_root[RW] == '0) ? RW'(1) : sq_root[RW];
  assign half_sum     = {1'b0, root_f} + (RW+1)'(1);
  assign sc_en        = !sc_valid || sc_ready;
  assign sq_ready[RW] = sc_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (sc_en) begin
      sc_valid <= sq_valid[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (sc_en && sq_valid[RW]) begin
      for (int k = 0; k < 3; k++) begin
        sc_num[k] <= (NW'(sq_pay[RW].mag[k]) << F) + NW'(root_f);
      end
      sc_den  <= {root_f, 1'b0};
      sc_half <= half_sum[RW:1];
      sc_pay  <= sq_pay[RW];
    end
  end

  // ---------------- divide chain ----------------
  logic               dv_valid [NW+1];
  logic               dv_ready [NW+1];
  logic [2:0][NW-1:0] dv_num   [NW+1];
  logic [2:0][RW:0]   dv_rem   [NW+1];
  logic [2:0][NW-1:0] dv_q     [NW+1];
  logic [RW:0]        dv_den   [NW+1];
  logic [RW-1:0]      dv_half  [NW+1];
  rmq_pay_t           dv_pay   [NW+1];

  assign dv_valid[0] = sc_valid;
  assign sc_ready    = dv_ready[0];
  assign dv_num[0]   = sc_num;
  assign dv_rem[0]   = '0;
  assign dv_q[0]     = '0;
  assign dv_den[0]   = sc_den;
  assign dv_half[0]  = sc_half;
  assign dv_pay[0]   = sc_pay;

  for (genvar j = 0; j < NW; j++) begin : g_div
    rmq_div_cell #(.NW(NW), .RW(RW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[j]),
      .in_ready  (dv_ready[j]),
      .in_num    (dv_num[j]),
      .in_rem    (dv_rem[j]),
      .in_q      (dv_q[j]),
      .in_den    (dv_den[j]),
      .in_half   (dv_half[j]),
      .in_pay    (dv_pay[j]),
      .out_valid (dv_valid[j+1]),
      .out_ready (dv_ready[j+1]),
      .out_num   (dv_num[j+1]),
      .out_rem   (dv_rem[j+1]),
      .out_q     (dv_q[j+1]),
      .out_den   (dv_den[j+1]),
      .out_half  (dv_half[j+1]),
      .out_pay   (dv_pay[j+1])
    );
  end

  // ---------------- output: sign, saturate, place ----------------
  function automatic logic [15:0] pack_q(logic [NW-1:0] q, logic neg);
    logic [NW-1:0]        qs;
    logic signed [CW-1:0] v;
    qs = (q > NW'(ONE)) ? NW'(ONE) : q;
    v  = neg ? -$signed(CW'(qs)) : $signed(CW'(qs));
    if (v > $signed(CW'(32767))) v = CW'(32767);
    if (v < -$signed(CW'(32768))) v = -$signed(CW'(32768));
    return v[15:0];
  endfunction

  logic [1:0]        half_slot;
  logic [3:0][15:0]  slot;
  logic              out_en;
  rmq_pay_t          fp;

  assign fp = dv_pay[NW];

  always_comb begin
    case (fp.sel)
      SEL_TRACE: half_slot = 2'd3;
      SEL_X:     half_slot = 2'd0;
      SEL_Y:     half_slot = 2'd1;
      SEL_Z:     half_slot = 2'd2;
      default:   half_slot = 2'd3;
    endcase
    for (int s = 0; s < 4; s++) begin
      if (2'(s) == half_slot) begin
        slot[s] = pack_q(NW'(dv_half[NW]), 1'b0);
      end else if (2'(s) < half_slot) begin
        slot[s] = pack_q(dv_q[NW][s], fp.neg[s]);
      end else begin
        slot[s] = pack_q(dv_q[NW][s-1], fp.neg[s-1]);
      end
    end
  end

  assign out_en       = !m_tvalid || m_tready;
  assign dv_ready[NW] = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && dv_valid[NW]) begin
      m_tdata <= slot;
    end
  end

  // ---------------- checks ----------------
  a_rad_pos: assert property (@(posedge clk) disable iff (rst)
    prep_valid |-> prep_rad != '0)
    else $error("radicand reached the root chain as zero");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    sc_valid |-> sc_den != '0)
    else $error("zero divisor in divide chain");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(CW'($signed(m_tdata[15:0]))) <= $signed(CW'(ONE)) &&
                  $signed(CW'($signed(m_tdata[63:48]))) <= $signed(CW'(ONE))))
    else $error("output component above one");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && !prep_valid)
    else $error("valid flags not cleared by reset");

endmodule
